// ===== hw/rtl/vbdt_pkg.sv =====
// Shared constants and types for the version bits deployment tracker.
package vbdt_pkg;

  // Longest period / window the cell chain supports
  localparam int MaxPeriod = 2048;
  // Width of a window slot index and of a period length or window total
  localparam int IdxW      = $clog2(MaxPeriod);
  localparam int PerW      = IdxW + 1;

  // Fixed field widths
  localparam int VerW      = 32;
  localparam int TimeW     = 63;
  localparam int CfgW      = 63;
  localparam int CfgIdxW   = 3;
  localparam int CountW    = 12;
  localparam int StateW    = 3;

  // Per-cycle control broadcast along the window chain
  typedef struct packed {
    logic push;   // shift a counted block into the window
    logic clear;  // wipe the window after a period length write
  } win_ctl_t;

endpackage

// ===== hw/rtl/vbdt_cell.sv =====
// One slot of the signal window chain: holds one signal bit.
module vbdt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vbdt_pkg::win_ctl_t ctl_i,
  input  logic              insert_i,
  input  logic              new_bit_i,
  input  logic              prev_bit_i,
  output logic              bit_o
);

  logic bit_d, bit_q;

  // Entry cell takes the new bit, the rest take the neighbor's bit
  always_comb begin
    bit_d = bit_q;
    if (ctl_i.clear) begin
      bit_d = 1'b0;
    end else if (ctl_i.push) begin
      bit_d = insert_i ? new_bit_i : prev_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

// ===== hw/rtl/vbdt_window.sv =====
// Sliding signal window: a chain of one-bit cells plus the running signal total.
module vbdt_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vbdt_pkg::win_ctl_t          ctl_i,
  input  logic [vbdt_pkg::IdxW-1:0]   ins_idx_i,
  input  logic                        new_bit_i,
  output logic [vbdt_pkg::PerW-1:0]   total_q_o,
  output logic [vbdt_pkg::PerW-1:0]   total_d_o
);

  logic [vbdt_pkg::MaxPeriod-1:0] bits;
  logic [vbdt_pkg::PerW-1:0]      total_d, total_q;
  logic                           exit_bit;

  // New bits enter at slot MaxPeriod - period and leave at the far end,
  // so the leaving bit is the one pushed a full period ago (zero until filled).
  for (genvar g = 0; g < vbdt_pkg::MaxPeriod; g++) begin : g_cell
    logic prev_bit;
    if (g == 0) begin : g_head
      assign prev_bit = 1'b0;
    end else begin : g_body
      assign prev_bit = bits[g-1];
    end

    vbdt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_i),
      .insert_i   (ins_idx_i == vbdt_pkg::IdxW'(g)),
      .new_bit_i  (new_bit_i),
      .prev_bit_i (prev_bit),
      .bit_o      (bits[g])
    );
  end

  assign exit_bit = bits[vbdt_pkg::MaxPeriod-1];

  // Running total of signalling blocks in the window
  always_comb begin
    total_d = total_q;
    if (ctl_i.clear) begin
      total_d = '0;
    end else if (ctl_i.push) begin
      total_d = total_q - vbdt_pkg::PerW'(exit_bit) + vbdt_pkg::PerW'(new_bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  assign total_q_o = total_q;
  assign total_d_o = total_d;

endmodule

// ===== hw/rtl/version_bits_deployment_tracker_top.sv =====
// Top level of the version bits deployment tracker: config, period tracking, state.
//
// Blocks stream in height order from genesis, one transfer per block, and each
// block yields one result transfer carrying the deployment state for the next
// block, the signal count in the window, a period-end flag (tlast) and the
// block's own signalling flag. One block is taken every clock cycle: the window
// is a chain of one-bit cells that shift together on a push, the total is one
// add/subtract and the state step is one compare stage, all combinational ahead
// of the output register. A one-deep output register holds the result; a new
// block enters when that register is empty or its result is taken in the same
// cycle, so a result that waits holds the input off. The result is registered
// when its block is taken. Writing the period length wipes the window, its total
// and the period position; the deployment state is kept. Configure only while no
// block is in flight.
module version_bits_deployment_tracker_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic [vbdt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [vbdt_pkg::CfgW-1:0]   cfg_data_i,
  // Block stream in
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [95:0]                 s_axis_tdata,  // block_version[31:0], median_time[94:32], pad
  input  logic                        s_axis_tuser,  // algo_marked
  // Result stream out
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // next_state[2:0], window_count[14:3], pad
  output logic                        m_axis_tlast,  // period_end
  output logic                        m_axis_tuser   // block_signals
);

  typedef enum logic [vbdt_pkg::StateW-1:0] {
    ST_DEFINED = 3'd0,
    ST_STARTED = 3'd1,
    ST_LOCKED  = 3'd2,
    ST_ACTIVE  = 3'd3,
    ST_FAILED  = 3'd4
  } deploy_state_e;

  typedef enum logic [vbdt_pkg::CfgIdxW-1:0] {
    REG_START_TIME   = 3'd0,
    REG_TIMEOUT_TIME = 3'd1,
    REG_PERIOD_LEN   = 3'd2,
    REG_LOCK_THRESH  = 3'd3,
    REG_SIGNAL_BIT   = 3'd4,
    REG_ALGO_SKIP    = 3'd5
  } cfg_reg_e;

  localparam logic [11:0] PeriodRst = 12'd2016;
  localparam logic [11:0] ThreshRst = 12'd1916;
  localparam logic [2:0]  TopBits   = 3'b001;

  // Configuration registers
  logic [vbdt_pkg::TimeW-1:0] start_time_q, timeout_time_q;
  logic [11:0]                period_len_q, lock_thresh_q;
  logic [4:0]                 signal_bit_q;
  logic                       algo_skip_q;

  // Tracking state
  deploy_state_e              state_d, state_q;
  logic [vbdt_pkg::IdxW-1:0]  pos_d, pos_q;

  // Output register
  logic                       out_valid_q;
  logic [vbdt_pkg::StateW-1:0] out_state_q;
  logic [vbdt_pkg::CountW-1:0] out_count_q;
  logic                       out_end_q, out_sig_q;

  logic                       accept;
  logic                       period_wr;
  logic [vbdt_pkg::VerW-1:0]  ver;
  logic [vbdt_pkg::TimeW-1:0] mtp;
  logic                       marked;
  logic                       sig;
  logic                       closed;
  logic [vbdt_pkg::PerW-1:0]  per_eff;
  logic [vbdt_pkg::IdxW-1:0]  ins_idx;
  logic [vbdt_pkg::PerW-1:0]  total_q, total_d;
  vbdt_pkg::win_ctl_t         win_ctl;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign period_wr     = cfg_we_i && (cfg_idx_i == REG_PERIOD_LEN);

  assign ver    = s_axis_tdata[31:0];
  assign mtp    = s_axis_tdata[94:32];
  assign marked = s_axis_tuser;

  // Signalling: top bits 001 and the deployment bit set
  assign sig = (ver[31:29] == TopBits) && ver[signal_bit_q];

  // Effective period: zero acts as one, clamp to the chain length
  always_comb begin
    if (period_len_q == '0) begin
      per_eff = vbdt_pkg::PerW'(1);
    end else if (32'(period_len_q) > 32'(vbdt_pkg::MaxPeriod)) begin
      per_eff = vbdt_pkg::PerW'(vbdt_pkg::MaxPeriod);
    end else begin
      per_eff = vbdt_pkg::PerW'(period_len_q);
    end
  end

  assign ins_idx = vbdt_pkg::IdxW'(32'(vbdt_pkg::MaxPeriod) - 32'(per_eff));

  // Window control
  assign win_ctl.clear = period_wr;
  assign win_ctl.push  = accept && !(algo_skip_q && marked);

  vbdt_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (win_ctl),
    .ins_idx_i (ins_idx),
    .new_bit_i (sig),
    .total_q_o (total_q),
    .total_d_o (total_d)
  );

  // Period position and deployment state step
  assign closed = ({1'b0, pos_q} + vbdt_pkg::PerW'(1)) >= per_eff;

  always_comb begin
    pos_d   = pos_q;
    state_d = state_q;
    if (period_wr) begin
      pos_d = '0;
    end else if (accept) begin
      if (closed) begin
        pos_d = '0;
        case (state_q)
          ST_DEFINED: begin
            if (mtp < start_time_q) begin
              state_d = ST_DEFINED;
            end else if (mtp >= timeout_time_q) begin
              state_d = ST_FAILED;
            end else begin
              state_d = ST_STARTED;
            end
          end
          ST_STARTED: begin
            if (mtp >= timeout_time_q) begin
              state_d = ST_FAILED;
            end else if (32'(total_d) >= 32'(lock_thresh_q)) begin
              state_d = ST_LOCKED;
            end
          end
          ST_LOCKED: state_d = ST_ACTIVE;
          default:   state_d = state_q;
        endcase
      end else begin
        pos_d = pos_q + vbdt_pkg::IdxW'(1);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q   <= '1;
      timeout_time_q <= '1;
      period_len_q   <= PeriodRst;
      lock_thresh_q  <= ThreshRst;
      signal_bit_q   <= '0;
      algo_skip_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_TIME:   start_time_q   <= cfg_data_i;
        REG_TIMEOUT_TIME: timeout_time_q <= cfg_data_i;
        REG_PERIOD_LEN:   period_len_q   <= cfg_data_i[11:0];
        REG_LOCK_THRESH:  lock_thresh_q  <= cfg_data_i[11:0];
        REG_SIGNAL_BIT:   signal_bit_q   <= cfg_data_i[4:0];
        REG_ALGO_SKIP:    algo_skip_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Tracking state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DEFINED;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_state_q <= state_d;
      out_count_q <= vbdt_pkg::CountW'(total_d);
      out_end_q   <= closed;
      out_sig_q   <= sig;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_state_q};
  assign m_axis_tlast  = out_end_q;
  assign m_axis_tuser  = out_sig_q;

  // The window never holds more signalling blocks than the period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= per_eff)
    else $error("window total exceeds period length");

  // Without a period end the deployment state does not move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !closed) |=> (state_q == $past(state_q)))
    else $error("state changed inside a period");

  // Active and failed are terminal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACTIVE || state_q == ST_FAILED) |=> (state_q == $past(state_q)))
    else $error("left a terminal state");

  // A reported result reflects the state taken at its block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_valid_q && (out_state_q == state_q)))
    else $error("result state does not match tracker state");

endmodule

// ===== tb/version_bits_deployment_tracker_top_tb.sv =====
// Self-checking testbench for the version bits deployment tracker top level.
module version_bits_deployment_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vbdt_pkg::*;

  // Deployment states as they appear on the result stream
  typedef enum logic [StateW-1:0] {
    StDefined = 3'd0,
    StStarted = 3'd1,
    StLocked  = 3'd2,
    StActive  = 3'd3,
    StFailed  = 3'd4
  } dep_state_e;

  // Register map of the write port; 6 and 7 are unmapped
  typedef enum logic [CfgIdxW-1:0] {
    RegStart   = 3'd0,
    RegTimeout = 3'd1,
    RegPeriod  = 3'd2,
    RegThresh  = 3'd3,
    RegSigBit  = 3'd4,
    RegSkip    = 3'd5,
    RegSpare   = 3'd7
  } cfg_reg_e;

  // How the run ends up in a terminal state
  typedef enum logic [1:0] {EndLockIn, EndFailStarted, EndFailDefined} finale_e;

  typedef struct packed {
    dep_state_e        state;
    logic [CountW-1:0] count;
    logic              period_end;
    logic              signals;
  } block_result_t;

  typedef enum logic {RowBlock, RowWrite} row_kind_e;

  // One row of the directed table: a block transfer or a register write
  typedef struct packed {
    row_kind_e     kind;
    cfg_reg_e      idx;
    logic [62:0]   data;    // register value, or median time of a block
    logic [31:0]   ver;
    logic          marked;
    logic          known;   // expected result typed into the row
    block_result_t want;
  } plan_row_t;

  localparam logic [62:0] MaxTime     = '1;
  localparam int          DrainCycles = 3;
  localparam int          IdlePct     = 24;
  localparam int          CalmLo      = 200;  // no idling between these transfer counts
  localparam int          CalmHi      = 280;
  localparam int          HoldAt      = 100;  // result count at which the long stall starts
  localparam int          HoldCycles  = 80;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [95:0]         s_axis_tdata;   // block_version[31:0], median_time[94:32], pad
  logic                s_axis_tuser;   // algo_marked
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;   // next_state[2:0], window_count[14:3], pad
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  version_bits_deployment_tracker_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Tracker mirror: register copies
  logic [62:0]          reg_start   = MaxTime;
  logic [62:0]          reg_timeout = MaxTime;
  logic [11:0]          reg_period  = 12'd2016;
  logic [11:0]          reg_thresh  = 12'd1916;
  logic [4:0]           reg_sigbit  = 5'd0;
  logic                 reg_skip    = 1'b0;
  // Tracker mirror: deployment state and counting window
  dep_state_e           trk_state   = StDefined;
  logic [MaxPeriod-1:0] trk_win     = '0;
  int unsigned          trk_ptr     = 0;
  int unsigned          trk_fill    = 0;
  int unsigned          trk_total   = 0;
  int unsigned          trk_pos     = 0;

  block_result_t due_results[$];
  int unsigned   sent_cnt  = 0;
  int unsigned   rcvd_cnt  = 0;
  int unsigned   err_cnt   = 0;
  int unsigned   hold_left = 0;
  logic          hold_done = 1'b0;

  function automatic logic [62:0] rand63();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[62:0];
  endfunction

  // Random upper bits over a narrow register value
  function automatic logic [62:0] noisy(logic [62:0] val, int unsigned w);
    logic [62:0] keep;
    keep = (63'd1 << w) - 63'd1;
    return (rand63() & ~keep) | (val & keep);
  endfunction

  // Period length as the block uses it: 0 acts as 1, clipped at the window size
  function automatic int unsigned eff_len(logic [11:0] p);
    if (p == 12'd0) return 1;
    if (p > MaxPeriod) return MaxPeriod;
    return 32'(p);
  endfunction

  // Mostly short periods, with the edge lengths now and then
  function automatic logic [11:0] pick_period();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 12'($urandom_range(1, 8));
    if (r < 80) return 12'($urandom_range(9, 64));
    if (r < 87) return 12'd0;
    if (r < 93) return 12'(MaxPeriod);
    if (r < 96) return 12'hFFF;
    return 12'($urandom_range(65, 4095));
  endfunction

  // Register write as the block sees it
  function automatic void apply_reg(cfg_reg_e idx, logic [62:0] val);
    case (idx)
      RegStart:   reg_start   = val;
      RegTimeout: reg_timeout = val;
      RegPeriod: begin
        reg_period = val[11:0];
        trk_win    = '0;
        trk_ptr    = 0;
        trk_fill   = 0;
        trk_total  = 0;
        trk_pos    = 0;
      end
      RegThresh:  reg_thresh  = val[11:0];
      RegSigBit:  reg_sigbit  = val[4:0];
      RegSkip:    reg_skip    = val[0];
      default: ;
    endcase
  endfunction

  // Advance the mirror by one block and return the result it should produce
  function automatic block_result_t step_tracker(logic [31:0] ver, logic [62:0] mtp,
                                                 logic marked);
    int unsigned   per;
    logic          sig;
    block_result_t r;
    per = eff_len(reg_period);
    sig = (ver[31:29] == 3'b001) && ver[reg_sigbit];
    // counted blocks slide into the window
    if (!(reg_skip && marked)) begin
      if (trk_ptr >= per) trk_ptr = 0;
      if (trk_fill >= per) begin
        trk_total = trk_total - trk_win[trk_ptr];
        trk_fill  = per;
      end else begin
        trk_fill++;
      end
      trk_win[trk_ptr] = sig;
      trk_total        = trk_total + sig;
      trk_ptr          = (trk_ptr + 1 >= per) ? 0 : trk_ptr + 1;
    end
    // every block advances the period; the last one steps the state
    r.period_end = 1'b0;
    if (trk_pos + 1 >= per) begin
      r.period_end = 1'b1;
      trk_pos      = 0;
      case (trk_state)
        StDefined: begin
          if (mtp >= reg_start) trk_state = (mtp >= reg_timeout) ? StFailed : StStarted;
        end
        StStarted: begin
          if (mtp >= reg_timeout) trk_state = StFailed;
          else if (trk_total >= reg_thresh) trk_state = StLocked;
        end
        StLocked: trk_state = StActive;
        default: ;
      endcase
    end else begin
      trk_pos++;
    end
    r.state   = trk_state;
    r.count   = trk_total[11:0];
    r.signals = sig;
    return r;
  endfunction

  function automatic plan_row_t wr(cfg_reg_e idx, logic [62:0] val);
    plan_row_t row;
    row      = '0;
    row.kind = RowWrite;
    row.idx  = idx;
    row.data = val;
    return row;
  endfunction

  function automatic plan_row_t blk(logic [31:0] ver, logic [62:0] mtp, logic marked);
    plan_row_t row;
    row        = '0;
    row.kind   = RowBlock;
    row.ver    = ver;
    row.data   = mtp;
    row.marked = marked;
    return row;
  endfunction

  function automatic plan_row_t blk_chk(logic [31:0] ver, logic [62:0] mtp, logic marked,
                                        dep_state_e st, logic [11:0] cnt, logic pend,
                                        logic sig);
    plan_row_t row;
    row                 = blk(ver, mtp, marked);
    row.known           = 1'b1;
    row.want.state      = st;
    row.want.count      = cnt;
    row.want.period_end = pend;
    row.want.signals    = sig;
    return row;
  endfunction

  // Offer one block, wait for its transfer, then queue its expected result
  task automatic push_block(input logic [31:0] ver, input logic [62:0] mtp, input logic marked,
                            input logic known, input block_result_t want);
    block_result_t calc;
    if (!(sent_cnt >= CalmLo && sent_cnt < CalmHi) && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, mtp, ver};
    s_axis_tuser  <= marked;
    do @(posedge clk_i); while (!s_axis_tready);
    calc = step_tracker(ver, mtp, marked);
    due_results.insert(due_results.size(), known ? want : calc);
    sent_cnt++;
  endtask

  // Registers change only with the block idle and every result back
  task automatic write_reg(input cfg_reg_e idx, input logic [62:0] val);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Mostly well-formed version words; keep_low keeps median time below the maximum
  task automatic random_blocks(input int n, input int sig_pct, input logic keep_low);
    logic [31:0] ver;
    logic [62:0] mtp;
    for (int i = 0; i < n; i++) begin
      ver = $urandom();
      if ($urandom_range(99) < 75) begin
        ver[31:29] = 3'b001;
        if ($urandom_range(99) < sig_pct) ver[reg_sigbit] = 1'b1;
      end
      mtp = rand63();
      if (keep_low && mtp == MaxTime) mtp = mtp - 63'd1;
      push_block(ver, mtp, $urandom_range(99) < 25, 1'b0, '0);
    end
  endtask

  // Result side: check each transfer, then pick tready for the next cycle
  always @(posedge clk_i) begin : result_sink
    block_result_t got;
    block_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.state      = dep_state_e'(m_axis_tdata[2:0]);
      got.count      = m_axis_tdata[14:3];
      got.period_end = m_axis_tlast;
      got.signals    = m_axis_tuser;
      if (due_results.size() == 0) begin
        $error("result transfer with no block outstanding");
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        if (got.state !== want.state) begin
          $error("next_state: expected %0d, got %0d", want.state, got.state);
          err_cnt++;
        end
        if (got.count !== want.count) begin
          $error("window_count: expected %0d, got %0d", want.count, got.count);
          err_cnt++;
        end
        if (got.period_end !== want.period_end) begin
          $error("period_end: expected %0b, got %0b", want.period_end, got.period_end);
          err_cnt++;
        end
        if (got.signals !== want.signals) begin
          $error("block_signals: expected %0b, got %0b", want.signals, got.signals);
          err_cnt++;
        end
      end
      rcvd_cnt++;
    end
    // one long stall so the block backs up into its input
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && rcvd_cnt == HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (rcvd_cnt >= CalmLo && rcvd_cnt < CalmHi) ||
                       ($urandom_range(99) >= IdlePct);
    end
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    finale_e     finale;
    logic [11:0] per;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part; the state stays defined throughout
    plan = '{
      // out of reset: long default period, skipping off, so a marked block counts
      blk_chk(32'h2000_0001, '0, 1'b1, StDefined, 12'd1, 1'b0, 1'b1),
      wr(RegPeriod, 63'd4), wr(RegThresh, 63'd3), wr(RegStart, 63'd1000),
      wr(RegTimeout, '0), wr(RegSigBit, '0), wr(RegSkip, 63'd1),
      blk_chk(32'h2000_0001, '0, 1'b0, StDefined, 12'd1, 1'b0, 1'b1),
      // top bits 111: never signals
      blk_chk(32'hFFFF_FFFF, MaxTime, 1'b0, StDefined, 12'd1, 1'b0, 1'b0),
      // marked block skipped by the window but still advancing the period
      blk_chk(32'h2000_0001, 63'd60, 1'b1, StDefined, 12'd1, 1'b0, 1'b1),
      // period closes before the start time
      blk_chk(32'h3FFF_FFFF, 63'd999, 1'b0, StDefined, 12'd2, 1'b1, 1'b1),
      // median time going backward, window wrapping
      blk(32'h0000_0000, 63'd10, 1'b0), blk(32'h2000_0001, 63'd5, 1'b1),
      blk(32'hDFFF_FFFE, '0, 1'b0), blk(32'h2000_0001, 63'd7, 1'b0),
      blk(32'h2000_0001, 63'd8, 1'b0),
      // deployment bit inside the top bits
      wr(RegSigBit, 63'd31), wr(RegSkip, '0),
      blk(32'hFFFF_FFFF, 63'd20, 1'b1), blk(32'h2000_0000, 63'd21, 1'b0),
      // zero period acts as one; unmapped register index
      wr(RegSigBit, 63'd28), wr(RegPeriod, '0), wr(RegSpare, 63'h2A5A_5A5A_5A5A_5A5A),
      blk(32'h3000_0000, 63'd30, 1'b0), blk(32'h2FFF_FFFF, 63'd31, 1'b1),
      blk(32'h3000_0000, 63'd29, 1'b0),
      // oversize period clips to the window size
      wr(RegPeriod, 63'd4095), wr(RegThresh, 63'd4095),
      blk(32'h3000_0000, 63'd40, 1'b0), blk(32'h1000_0000, 63'd41, 1'b1)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        push_block(plan[i].ver, plan[i].data, plan[i].marked, plan[i].known, plan[i].want);
      end
    end

    // Still defined: start time at its maximum, window settings vary
    write_reg(RegStart, MaxTime);
    for (int p = 0; p < 8; p++) begin
      write_reg(RegPeriod, noisy(63'(pick_period()), 12));
      write_reg(RegThresh, noisy(63'($urandom_range(0, 4095)), 12));
      write_reg(RegSigBit, noisy(($urandom_range(99) < 85) ? 63'($urandom_range(0, 28)) :
                                 63'($urandom_range(29, 31)), 5));
      write_reg(RegSkip, noisy(63'($urandom_range(1)), 1));
      write_reg(RegTimeout, rand63());
      random_blocks(40, 50, 1'b1);
    end

    // Started: threshold out of reach, no timeout
    finale = finale_e'($urandom_range(2));
    if (finale != EndFailDefined) begin
      write_reg(RegStart, '0);
      write_reg(RegTimeout, MaxTime);
      for (int p = 0; p < 3; p++) begin
        per = pick_period();
        write_reg(RegPeriod, 63'(per));
        write_reg(RegThresh, 63'($urandom_range(eff_len(per) + 1, 4095)));
        write_reg(RegSigBit, 63'($urandom_range(0, 31)));
        write_reg(RegSkip, 63'($urandom_range(1)));
        random_blocks(30, 50, 1'b1);
      end
    end

    // Drive into a terminal state and keep going there
    per = 12'($urandom_range(1, 8));
    write_reg(RegPeriod, 63'(per));
    case (finale)
      EndLockIn: begin
        write_reg(RegThresh, 63'($urandom_range(0, eff_len(per))));
        write_reg(RegSigBit, 63'($urandom_range(0, 28)));
        write_reg(RegSkip, 63'($urandom_range(1)));
        random_blocks(80, 95, 1'b1);
      end
      EndFailStarted: begin
        write_reg(RegThresh, 63'd4095);
        write_reg(RegTimeout, ($urandom_range(3) == 0) ? '0 : rand63());
        random_blocks(80, 50, 1'b0);
      end
      default: begin
        write_reg(RegStart, '0);
        write_reg(RegTimeout, '0);
        random_blocks(170, 50, 1'b0);
      end
    endcase

    // Let every result come back
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("version_bits_deployment_tracker_top regression: pass");
    end else begin
      $display("version_bits_deployment_tracker_top regression: fail");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #4_000_000;
    $display("version_bits_deployment_tracker_top regression: fail");
    $finish;
  end

endmodule

// ===== version_bits_deployment_tracker_top.f =====
hw/rtl/vbdt_pkg.sv
hw/rtl/vbdt_cell.sv
hw/rtl/vbdt_window.sv
hw/rtl/version_bits_deployment_tracker_top.sv
tb/version_bits_deployment_tracker_top_tb.sv
